### sv/triac_phase_angle_firing_unit_macros.svh
// Assertion macros used by the triac firing unit checker.
`ifndef TRIAC_PHASE_ANGLE_FIRING_UNIT_MACROS_SVH
`define TRIAC_PHASE_ANGLE_FIRING_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define TPAF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset.
`define TPAF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tpaf_pkg.sv
// Types and constants of the triac phase-angle firing unit.
package tpaf_pkg;

  localparam int unsigned SINCE_EDGE_BITS_DEF = 18;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_ON = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POWER     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DELAY = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE     = 3'd4;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Register reset values
  localparam logic [15:0] HALF_RST  = 16'd10000;
  localparam logic [15:0] MIN_RST   = 16'd500;
  localparam logic [11:0] PULSE_RST = 12'd100;

  // Period filter and mains detection
  localparam int unsigned PERIOD_LOW    = 17000;
  localparam int unsigned PERIOD_HIGH   = 23000;
  localparam int unsigned PRESENT_LIMIT = 200000;
  localparam int unsigned FULL_POWER    = 100;

  // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^30 / 76
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_100   = 24'd10737419;

  // Cycles from a register write until the firing windows are current
  localparam int unsigned SETTLE_BITS = 3;
  localparam logic [SETTLE_BITS-1:0] CFG_SETTLE = 3'd5;

  // Firing windows relative to the last edge: [start, end)
  typedef struct packed {
    logic [15:0] win1_start;
    logic [16:0] win1_end;
    logic [16:0] win2_start;
    logic [17:0] win2_end;
  } win_t;

endpackage

### sv/tpaf_delay_calc.sv
// Pipelined firing-delay calculation from the configuration registers.
module tpaf_delay_calc (
  input  logic               clk_i,
  input  logic [6:0]         power_i,
  input  logic [15:0]        half_i,
  input  logic [15:0]        min_delay_i,
  input  logic [11:0]        pulse_i,
  output tpaf_pkg::win_t     win_o
);

  logic [6:0]         pclamp;
  logic [6:0]         neg_pow;
  logic signed [16:0] span;
  logic signed [23:0] prod_d, prod_q;
  logic [22:0]        prod_abs;
  logic [46:0]        recip_full;
  logic [15:0]        quot_d, quot_q;
  logic               neg_d, neg_q;
  logic [15:0]        delay_d, delay_q;
  tpaf_pkg::win_t     win_d, win_q;

  // stage 1: (100 - p) * (half - min), both operands widened to the product width
  always_comb begin
    pclamp  = (power_i > 7'(tpaf_pkg::FULL_POWER)) ? 7'(tpaf_pkg::FULL_POWER) : power_i;
    neg_pow = 7'(tpaf_pkg::FULL_POWER) - pclamp;
    span    = $signed({1'b0, half_i}) - $signed({1'b0, min_delay_i});
    prod_d  = $signed({17'd0, neg_pow}) * $signed({{7{span[16]}}, span});
  end

  // stage 2: divide magnitude by 100, truncation toward zero
  always_comb begin
    prod_abs   = prod_q[23] ? 23'(-prod_q) : prod_q[22:0];
    recip_full = 47'(prod_abs) * 47'(tpaf_pkg::RECIP_100);
    quot_d     = recip_full[tpaf_pkg::RECIP_SHIFT +: 16];
    neg_d      = prod_q[23];
  end

  // stage 3: add minimum delay
  assign delay_d = neg_q ? (min_delay_i - quot_q) : (min_delay_i + quot_q);

  // stage 4: window bounds
  always_comb begin
    win_d.win1_start = delay_q;
    win_d.win1_end   = 17'(delay_q) + 17'(pulse_i);
    win_d.win2_start = 17'(delay_q) + 17'(half_i);
    win_d.win2_end   = 18'(delay_q) + 18'(half_i) + 18'(pulse_i);
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    quot_q  <= quot_d;
    neg_q   <= neg_d;
    delay_q <= delay_d;
    win_q   <= win_d;
  end

  assign win_o = win_q;

endmodule

### sv/triac_phase_angle_firing_unit.sv
// Top level of the triac phase-angle firing unit.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------------------
//   input    | in_valid_i / in_ready_o     | zcd_edge_i
//   result   | out_valid_o / out_ready_i   | gate_o, ac_period_us_o, mains_present_o
//   config   | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One item per cycle unless held off; each result is valid the cycle after its tick.
// The tick counter, period filter and gate compare are one combinational pass into the
// result register; the firing delay comes from a four-stage pipeline fed by the registers.
// After reset and after each register write the input is held off while
// that pipeline settles. Config writes are always taken.
// A stalled result holds the input off; it resumes the cycle the result is taken.
module triac_phase_angle_firing_unit #(
  parameter int unsigned SINCE_EDGE_BITS = tpaf_pkg::SINCE_EDGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              zcd_edge_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              gate_o,
  output logic [14:0]                       ac_period_us_o,
  output logic                              mains_present_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpaf_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [tpaf_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned T = SINCE_EDGE_BITS;

  // registers
  logic        output_on_q;
  logic [6:0]  power_q;
  logic [15:0] half_q;
  logic [15:0] min_delay_q;
  logic [11:0] pulse_q;

  logic [tpaf_pkg::SETTLE_BITS-1:0] settle_q, settle_d;

  // tick state
  logic [T-1:0] ticks_q, ticks_d;
  logic [14:0]  filt_q, filt_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        gate_q, gate_d;
  logic        present_q, present_d;

  logic           in_acc;
  logic           cfg_acc;
  logic [T-1:0]   ticks_inc;
  logic [18:0]    filt_sum;
  logic           in_window;
  logic           fire_en;
  tpaf_pkg::win_t win;

  tpaf_delay_calc u_delay (
    .clk_i       (clk_i),
    .power_i     (power_q),
    .half_i      (half_q),
    .min_delay_i (min_delay_q),
    .pulse_i     (pulse_q),
    .win_o       (win)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  // take a tick when the windows are current and the result slot frees up
  assign in_ready_o = (settle_q == '0) & (~out_valid_q | out_ready_i);
  assign in_acc     = in_valid_i & in_ready_o;

  always_comb begin
    settle_d = settle_q;
    if (cfg_acc) begin
      settle_d = tpaf_pkg::CFG_SETTLE;
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
  end

  // tick pass: count, measure, filter, fire
  always_comb begin
    ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
    in_window = (ticks_inc > T'(tpaf_pkg::PERIOD_LOW)) &&
                (ticks_inc < T'(tpaf_pkg::PERIOD_HIGH));
    // (7*old + new) >> 3
    filt_sum  = {1'b0, filt_q, 3'b000} - 19'(filt_q) + 19'(ticks_inc[14:0]);

    ticks_d = ticks_inc;
    filt_d  = filt_q;
    if (zcd_edge_i) begin
      if (in_window) begin
        filt_d = (filt_q == '0) ? ticks_inc[14:0] : filt_sum[17:3];
      end
      ticks_d = '0;
    end

    fire_en = output_on_q & (power_q != '0);
    gate_d  = fire_en &&
              (((ticks_d >= T'(win.win1_start)) && (ticks_d < T'(win.win1_end))) ||
               ((ticks_d >= T'(win.win2_start)) && (ticks_d < T'(win.win2_end))));
    present_d = (filt_d != '0) && (ticks_d < T'(tpaf_pkg::PRESENT_LIMIT));
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_on_q <= 1'b0;
      power_q     <= '0;
      half_q      <= tpaf_pkg::HALF_RST;
      min_delay_q <= tpaf_pkg::MIN_RST;
      pulse_q     <= tpaf_pkg::PULSE_RST;
      settle_q    <= tpaf_pkg::CFG_SETTLE;
      ticks_q     <= '1;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      settle_q    <= settle_d;
      out_valid_q <= out_valid_d;
      if (cfg_acc) begin
        unique case (cfg_index_i)
          tpaf_pkg::CFG_OUTPUT_ON: output_on_q <= cfg_data_i[0];
          tpaf_pkg::CFG_POWER:     power_q     <= cfg_data_i[6:0];
          tpaf_pkg::CFG_HALF:      half_q      <= cfg_data_i;
          tpaf_pkg::CFG_MIN_DELAY: min_delay_q <= cfg_data_i;
          tpaf_pkg::CFG_PULSE:     pulse_q     <= cfg_data_i[11:0];
          default: ; // unknown index, write dropped
        endcase
      end
      if (in_acc) begin
        ticks_q <= ticks_d;
        filt_q  <= filt_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gate_q    <= gate_d;
      present_q <= present_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gate_o          = gate_q;
  assign ac_period_us_o  = filt_q;
  assign mains_present_o = present_q;

endmodule

### sv/tpaf_checker.sv
// Port-level checker for the triac firing unit, bound to the top level.
`include "triac_phase_angle_firing_unit_macros.svh"

module tpaf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        gate_o,
  input logic [14:0] ac_period_us_o,
  input logic        mains_present_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // a stalled result item holds its payload
  `TPAF_ASSERT_NXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(gate_o) && $stable(ac_period_us_o) && $stable(mains_present_o), "result changed while stalled")

  // no tick is taken while a result waits
  `TPAF_ASSERT_IMP(a_stall, out_valid_o && !out_ready_i, !in_ready_o, "input ready during result stall")

  // a register write holds ticks off while the delay settles
  `TPAF_ASSERT_NXT(a_settle, cfg_valid_i && cfg_ready_o, !in_ready_o, "input ready right after config write")

  // filtered period is zero or inside the accepted window, and zero means no mains
  `TPAF_ASSERT_IMP(a_period, out_valid_o, (ac_period_us_o == 15'd0 && !mains_present_o) || (ac_period_us_o > 15'd17000 && ac_period_us_o < 15'd23000), "bad filtered period")

endmodule

bind triac_phase_angle_firing_unit tpaf_checker u_tpaf_checker (.*);
